[rtl/length_prefixed_utf8_frame_receiver_macros.svh]
// Assertion macros shared by the frame receiver RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef LENGTH_PREFIXED_UTF8_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_PREFIXED_UTF8_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LPU8_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LPU8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/lpu8_pkg.sv]
// Shared types and constants of the length-prefixed UTF-8 frame receiver.
// Depends on nothing; imported by every module of the block.
package lpu8_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int LEN_W = 21;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 21'h010000;

   // Result status codes.
   localparam logic [1:0] ST_BUSY      = 2'd0;
   localparam logic [1:0] ST_FRAME_OK  = 2'd1;
   localparam logic [1:0] ST_PROTO_ERR = 2'd2;
   localparam logic [1:0] ST_CLEAN_END = 2'd3;

   // Code point limits for the strict UTF-8 check.
   localparam logic [20:0] CP_MIN3 = 21'h000800;
   localparam logic [20:0] CP_MIN4 = 21'h010000;
   localparam logic [20:0] CP_MAX  = 21'h10ffff;
   localparam logic [20:0] SURR_LO = 21'h00d800;
   localparam logic [20:0] SURR_HI = 21'h00dfff;

   typedef enum logic [2:0] {
      KIND_ASCII,
      KIND_CONT,
      KIND_LEAD2,
      KIND_LEAD3,
      KIND_LEAD4,
      KIND_INVALID
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       payload_byte;
      logic             payload_byte_valid;
      logic             frame_last;
      logic [LEN_W-1:0] frame_length;
   } rsp_type;

   // A classified byte as it sits in the queue.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
      logic       class_ok;
      kind_type   kind;
   } item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

endpackage

[rtl/lpu8_front.sv]
// Front end: takes input transfers and classifies each byte for the back end.
// Depends on lpu8_pkg.
module lpu8_front (
   input  logic               req_valid,
   output logic               req_stall,
   input  lpu8_pkg::req_type  req_item,
   input  lpu8_pkg::qstat_type q_stat,
   output logic               q_push,
   output lpu8_pkg::item_type q_item
);
   import lpu8_pkg::*;

   kind_type kind;

   assign req_stall = q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   always_comb begin
      case (req_item.data_byte) inside
         [8'h00:8'h7f]: kind = KIND_ASCII;
         [8'h80:8'hbf]: kind = KIND_CONT;
         [8'hc2:8'hdf]: kind = KIND_LEAD2;
         [8'he0:8'hef]: kind = KIND_LEAD3;
         [8'hf0:8'hf4]: kind = KIND_LEAD4;
         default:       kind = KIND_INVALID;
      endcase
   end

   always_comb begin
      q_item.data_byte     = req_item.data_byte;
      q_item.end_of_stream = req_item.end_of_stream;
      // Controls below space are refused except tab; DEL is refused too.
      q_item.class_ok      = !((req_item.data_byte < 8'h20 && req_item.data_byte != 8'h09)
                               || req_item.data_byte == 8'h7f);
      q_item.kind          = kind;
   end

endmodule

[rtl/lpu8_queue.sv]
// Short FIFO of classified bytes between the front and back ends.
// Depends on lpu8_pkg.
module lpu8_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lpu8_pkg::item_type  push_item,
   input  logic                pop,
   output lpu8_pkg::item_type  head_item,
   output lpu8_pkg::qstat_type stat
);
   import lpu8_pkg::*;

   item_type            ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   assign head_item      = ent_ff[rd_ptr_ff];
   assign stat.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.not_empty = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/lpu8_back.sv]
// Back end: framing state machine, UTF-8 decoder and registered result stage.
// Depends on lpu8_pkg.
module lpu8_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lpu8_pkg::LEN_W-1:0]   csr_wdata,
   input  lpu8_pkg::qstat_type          q_stat,
   input  lpu8_pkg::item_type           q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output lpu8_pkg::rsp_type            rsp_item
);
   import lpu8_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_GOOD,
      PH_BAD,
      PH_ERROR
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [1:0]       hcnt_ff, hcnt_in;
   logic [23:0]      hdr_ff, hdr_in;
   logic [LEN_W-1:0] plen_ff, plen_in;
   logic [LEN_W-1:0] pcnt_ff, pcnt_in;
   logic [1:0]       cont_ff, cont_in;
   logic [1:0]       seq_ff, seq_in;
   logic [20:0]      cp_ff, cp_in;
   logic [LEN_W-1:0] max_ff, max_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [31:0]      hdr_len;
   logic [LEN_W-1:0] pcnt_inc;
   logic             utf_ok;

   assign csr_ready = 1'b1;
   assign q_pop     = q_stat.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      phase_in = phase_ff;
      hcnt_in  = hcnt_ff;
      hdr_in   = hdr_ff;
      plen_in  = plen_ff;
      pcnt_in  = pcnt_ff;
      cont_in  = cont_ff;
      seq_in   = seq_ff;
      cp_in    = cp_ff;
      max_in   = (csr_valid && csr_ready) ? csr_wdata : max_ff;
      rsp_in   = '0;
      rsp_in.status = ST_BUSY;
      hdr_len  = {hdr_ff, q_item.data_byte};
      pcnt_inc = pcnt_ff + LEN_W'(1);
      utf_ok   = 1'b1;

      if (phase_ff == PH_ERROR) begin
         rsp_in.status = ST_PROTO_ERR;
      end else if (q_item.end_of_stream) begin
         if (phase_ff == PH_HEADER && hcnt_ff == 2'd0) begin
            rsp_in.status = ST_CLEAN_END;
         end else begin
            rsp_in.status = ST_PROTO_ERR;
            phase_in      = PH_ERROR;
         end
      end else if (phase_ff == PH_HEADER) begin
         if (hcnt_ff == 2'd3) begin
            hcnt_in = 2'd0;
            hdr_in  = '0;
            if (hdr_len == 32'd0 || hdr_len > {11'd0, max_ff}) begin
               rsp_in.status = ST_PROTO_ERR;
               phase_in      = PH_ERROR;
            end else begin
               rsp_in.frame_length = hdr_len[LEN_W-1:0];
               plen_in  = hdr_len[LEN_W-1:0];
               phase_in = PH_GOOD;
               pcnt_in  = '0;
               cont_in  = 2'd0;
               seq_in   = 2'd0;
               cp_in    = '0;
            end
         end else begin
            hcnt_in = hcnt_ff + 2'd1;
            hdr_in  = hdr_len[23:0];
         end
      end else begin
         rsp_in.payload_byte       = q_item.data_byte;
         rsp_in.payload_byte_valid = 1'b1;
         rsp_in.frame_length       = plen_ff;

         if (phase_ff == PH_GOOD) begin
            if (!q_item.class_ok) begin
               utf_ok = 1'b0;
            end else if (cont_ff == 2'd0) begin
               case (q_item.kind)
                  KIND_ASCII: begin
                  end
                  KIND_LEAD2: begin
                     cp_in   = {16'd0, q_item.data_byte[4:0]};
                     seq_in  = 2'd1;
                     cont_in = 2'd1;
                  end
                  KIND_LEAD3: begin
                     cp_in   = {17'd0, q_item.data_byte[3:0]};
                     seq_in  = 2'd2;
                     cont_in = 2'd2;
                  end
                  KIND_LEAD4: begin
                     cp_in   = {18'd0, q_item.data_byte[2:0]};
                     seq_in  = 2'd3;
                     cont_in = 2'd3;
                  end
                  default: begin
                     utf_ok = 1'b0;
                  end
               endcase
            end else if (q_item.kind != KIND_CONT) begin
               utf_ok = 1'b0;
            end else begin
               cp_in   = {cp_ff[14:0], q_item.data_byte[5:0]};
               cont_in = cont_ff - 2'd1;
               if (cont_in == 2'd0) begin
                  // Sequence complete: reject overlong forms, surrogates and
                  // anything beyond the Unicode range.
                  if ((seq_ff == 2'd2 && cp_in < CP_MIN3)
                      || (seq_ff == 2'd3 && cp_in < CP_MIN4)
                      || cp_in > CP_MAX
                      || (cp_in >= SURR_LO && cp_in <= SURR_HI)) begin
                     utf_ok = 1'b0;
                  end
               end
            end
            if (!utf_ok) begin
               phase_in = PH_BAD;
            end
         end

         if (pcnt_inc == plen_ff) begin
            rsp_in.frame_last = 1'b1;
            // A sequence cut off by the end of the frame spoils it.
            if (phase_in == PH_GOOD && cont_in != 2'd0) begin
               phase_in = PH_BAD;
            end
            if (phase_in == PH_GOOD) begin
               rsp_in.status = ST_FRAME_OK;
               phase_in      = PH_HEADER;
            end else begin
               rsp_in.status = ST_PROTO_ERR;
               phase_in      = PH_ERROR;
            end
            pcnt_in = '0;
         end else begin
            pcnt_in = pcnt_inc;
         end
      end

      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hcnt_ff      <= 2'd0;
         hdr_ff       <= '0;
         plen_ff      <= '0;
         pcnt_ff      <= '0;
         cont_ff      <= 2'd0;
         seq_ff       <= 2'd0;
         cp_ff        <= '0;
         max_ff       <= MAX_PAYLOAD_RESET;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff <= phase_in;
            hcnt_ff  <= hcnt_in;
            hdr_ff   <= hdr_in;
            plen_ff  <= plen_in;
            pcnt_ff  <= pcnt_in;
            cont_ff  <= cont_in;
            seq_ff   <= seq_in;
            cp_ff    <= cp_in;
            rsp_ff   <= rsp_in;
         end
      end
   end

endmodule

[rtl/length_prefixed_utf8_frame_receiver.sv]
// Top level of the length-prefixed UTF-8 frame receiver.
// Depends on lpu8_pkg, lpu8_front, lpu8_queue, lpu8_back and the macros header.
//
// The receiver takes a byte stream, one byte per transfer, in which every
// frame is a four-byte big-endian length followed by that many payload bytes.
// Exactly one result transfer comes out for every input transfer. Header bytes
// answer "in progress"; the fourth header byte also reports the accepted
// length. Payload bytes are passed through on payload_byte with
// payload_byte_valid set, and the last one carries frame_last together with
// the verdict: frame complete and valid, or protocol error. A consumer should
// therefore buffer a frame and drop it when its last byte reports an error.
// The payload must be strict UTF-8 with no control bytes other than tab and no
// DEL. A length of zero or above max_payload, a bad payload, or end of stream
// inside a header or payload is a protocol error, and every later result is a
// protocol error until reset. End of stream at a frame boundary answers clean
// end and may be repeated. max_payload (reset 65536) is written through the
// csr port, which is always ready; write it only while no transfer is in
// flight. Throughput is one byte per clock while rsp_stall is low; the framing
// and UTF-8 state is updated in the back end. A byte's result passes through
// the queue and the result register to the result port and is transferred at
// an edge with rsp_stall low. A two-entry queue between the classifying
// front end and the back end, plus the result register, lets the input keep
// flowing while a result waits on rsp_stall; req_stall rises only when the
// queue is full.
`include "length_prefixed_utf8_frame_receiver_macros.svh"

module length_prefixed_utf8_frame_receiver (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lpu8_pkg::req_type          req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lpu8_pkg::rsp_type          rsp_item,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lpu8_pkg::LEN_W-1:0] csr_wdata
);
   import lpu8_pkg::*;

   qstat_type q_stat;
   item_type  push_item;
   item_type  head_item;
   logic      q_push;
   logic      q_pop;

   // Front end: accepts a transfer whenever the queue has room and tags the
   // byte with its character class and UTF-8 role.
   lpu8_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   // Decoupling queue between the two halves.
   lpu8_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   // Back end: framing, length check, UTF-8 decoding and the result register.
   lpu8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .q_item    (head_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // The queue is never written while full, so no accepted byte is lost.
   `LPU8_ASSERT_IMPLIES(a_no_overflow, clock, reset, q_stat.full, !q_push,
                        "queue overflow")

   // A valid frame verdict only ever comes with the frame's last payload byte.
   `LPU8_ASSERT_IMPLIES(a_ok_on_last, clock, reset,
                        rsp_valid && rsp_item.status == ST_FRAME_OK,
                        rsp_item.frame_last && rsp_item.payload_byte_valid,
                        "frame verdict off the last byte")

   // A protocol error is sticky: once one is delivered, no other status follows.
   `LPU8_ASSERT_NEXT(a_sticky_error, clock, reset,
                     rsp_valid && !rsp_stall && rsp_item.status == ST_PROTO_ERR,
                     !rsp_valid || rsp_item.status == ST_PROTO_ERR,
                     "error not sticky")

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the length-prefixed UTF-8 frame receiver.
// Depends on lpu8_pkg and length_prefixed_utf8_frame_receiver; runs stand-alone.
`timescale 1ns / 1ps

module tb_top;
   import lpu8_pkg::*;

   // Run shape. The stream is built from about ITEMS bytes. The watchdog ends
   // the run when its count of quiet cycles, with no transfer of any kind, reaches WATCHDOG_LIMIT.
   localparam int ITEMS          = 550;
   localparam int MAX_REG        = 1048576;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_AT        = 2 * ITEMS / 3 + 30;
   localparam int HOLD_CYCLES    = 64;
   localparam int DIR_ROWS       = 26;

   // Framing state of the receiver as the scoreboard tracks it.
   typedef enum logic [1:0] {
      RX_HEADER,
      RX_GOOD,
      RX_BAD,
      RX_STUCK
   } rx_phase_type;

   // Ways of ending the stream in a protocol error. An error is sticky until
   // reset and reset is applied only once, so exactly one of these closes the
   // run, picked at random.
   typedef enum {
      BRK_ZERO_LEN,
      BRK_OVER_LEN,
      BRK_NO_MAX,
      BRK_EOS_HEADER,
      BRK_EOS_PAYLOAD,
      BRK_BAD_CLASS,
      BRK_BAD_UTF8,
      BRK_TRUNCATED
   } break_kind_type;

   // One row of the directed table. Where fixed is set, the expected result
   // is the one typed into the row; otherwise the scoreboard computes it.
   typedef struct packed {
      req_type item;
      logic    fixed;
      rsp_type rsp;
   } dir_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_item  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_item;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_wdata = '0;

   length_prefixed_utf8_frame_receiver i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Scoreboard copy of the receiver state and of max_payload.
   rx_phase_type     rx_phase  = RX_HEADER;
   logic [1:0]       hdr_cnt   = '0;
   logic [31:0]      len_acc   = '0;
   logic [20:0]      pay_cnt   = '0;
   logic [1:0]       cont_left = '0;
   logic [1:0]       seq_size  = '0;
   logic [20:0]      cp_acc    = '0;
   logic [LEN_W-1:0] max_model = MAX_PAYLOAD_RESET;

   // Results still owed by the block, oldest first, and for every byte the
   // stimulus has put up, the row value typed in by hand if there is one.
   rsp_type          rsp_awaited[$];
   dir_row_type      hand_typed[$];

   int               in_accepted    = 0;
   int               mismatch_count = 0;
   int               quiet_cycles   = 0;
   int               hold_left      = 0;
   bit               hold_done      = 1'b0;

   // Stimulus-side bookkeeping: bytes put up so far, the register value in
   // force, and the frame being assembled.
   int               offered = 0;
   int               cur_max = int'(MAX_PAYLOAD_RESET);
   logic [7:0]       frame_bytes[$];

   dir_row_type      directed_rows[DIR_ROWS];

   // ------------------------------------------------------------------
   // Scoreboard
   // ------------------------------------------------------------------

   // Only tab is allowed below space, and DEL is never allowed.
   function automatic bit byte_allowed(input logic [7:0] data);
      if (data == 8'h7f) return 1'b0;
      if (data < 8'h20 && data != 8'h09) return 1'b0;
      return 1'b1;
   endfunction

   // Advances the strict UTF-8 decoder by one byte. A zero return means the
   // byte breaks the encoding: bad lead, missing continuation, overlong form,
   // surrogate, or a code point above 10FFFF.
   function automatic bit utf8_accept(input logic [7:0] data);
      if (cont_left == 2'd0) begin
         if (data <= 8'h7f) return 1'b1;
         if (data >= 8'hc2 && data <= 8'hdf) begin
            cp_acc = {16'd0, data[4:0]};
            seq_size = 2'd1;
            cont_left = 2'd1;
         end else if (data >= 8'he0 && data <= 8'hef) begin
            cp_acc = {17'd0, data[3:0]};
            seq_size = 2'd2;
            cont_left = 2'd2;
         end else if (data >= 8'hf0 && data <= 8'hf4) begin
            cp_acc = {18'd0, data[2:0]};
            seq_size = 2'd3;
            cont_left = 2'd3;
         end else begin
            return 1'b0;
         end
         return 1'b1;
      end
      if (data[7:6] != 2'b10) return 1'b0;
      cp_acc = {cp_acc[14:0], data[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
         if (seq_size == 2'd2 && cp_acc < CP_MIN3) return 1'b0;
         if (seq_size == 2'd3 && cp_acc < CP_MIN4) return 1'b0;
         if (cp_acc > CP_MAX) return 1'b0;
         if (cp_acc >= SURR_LO && cp_acc <= SURR_HI) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Result the receiver owes for one accepted byte; updates the tracked state.
   function automatic rsp_type rx_response(input req_type item);
      rsp_type    r;
      logic [7:0] data;
      r = '0;
      data = item.data_byte;
      if (rx_phase == RX_STUCK) begin
         r.status = ST_PROTO_ERR;
      end else if (item.end_of_stream) begin
         // Closing is clean only between frames.
         if (rx_phase == RX_HEADER && hdr_cnt == 2'd0) begin
            r.status = ST_CLEAN_END;
         end else begin
            r.status = ST_PROTO_ERR;
            rx_phase = RX_STUCK;
         end
      end else if (rx_phase == RX_HEADER) begin
         len_acc = {len_acc[23:0], data};
         if (hdr_cnt == 2'd3) begin
            hdr_cnt = 2'd0;
            if (len_acc == 32'd0 || len_acc > max_model) begin
               r.status = ST_PROTO_ERR;
               rx_phase = RX_STUCK;
            end else begin
               r.frame_length = len_acc[20:0];
               rx_phase = RX_GOOD;
               pay_cnt = '0;
               cont_left = '0;
               seq_size = '0;
               cp_acc = '0;
            end
         end else begin
            hdr_cnt = hdr_cnt + 2'd1;
         end
      end else begin
         r.payload_byte = data;
         r.payload_byte_valid = 1'b1;
         r.frame_length = len_acc[20:0];
         // Once a frame has gone bad its remaining bytes are not checked.
         if (rx_phase == RX_GOOD) begin
            if (!byte_allowed(data)) rx_phase = RX_BAD;
            else if (!utf8_accept(data)) rx_phase = RX_BAD;
         end
         pay_cnt = pay_cnt + 21'd1;
         if (pay_cnt == r.frame_length) begin
            r.frame_last = 1'b1;
            if (rx_phase == RX_GOOD && cont_left != 2'd0) rx_phase = RX_BAD;
            if (rx_phase == RX_GOOD) begin
               r.status = ST_FRAME_OK;
               rx_phase = RX_HEADER;
            end else begin
               r.status = ST_PROTO_ERR;
               rx_phase = RX_STUCK;
            end
            len_acc = '0;
            pay_cnt = '0;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH %s: expected %0h, got %0h, at %0t", what, want, got, $realtime);
      mismatch_count++;
   endtask

   // All transfers are observed in one process, so the order of predicting,
   // register capture and checking is fixed. Inputs are sampled before the
   // testbench's own nonblocking updates take effect.
   always @(posedge clock) begin
      rsp_type     want;
      rsp_type     got;
      dir_row_type typed;
      if (!reset) begin
         if (csr_valid && csr_ready) max_model = csr_wdata;
         if (req_valid && !req_stall) begin
            typed = (hand_typed.size() != 0) ? hand_typed.pop_front() : '0;
            want = rx_response(req_item);
            rsp_awaited.push_back(typed.fixed ? typed.rsp : want);
            in_accepted <= in_accepted + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_item;
            if (rsp_awaited.size() == 0) begin
               report_mismatch("result with nothing awaited", '0, 32'(got.status));
            end else begin
               want = rsp_awaited.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(got.status));
               if (got.payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", 32'(want.payload_byte),
                                  32'(got.payload_byte));
               if (got.payload_byte_valid !== want.payload_byte_valid)
                  report_mismatch("payload_byte_valid", 32'(want.payload_byte_valid),
                                  32'(got.payload_byte_valid));
               if (got.frame_last !== want.frame_last)
                  report_mismatch("frame_last", 32'(want.frame_last),
                                  32'(got.frame_last));
               if (got.frame_length !== want.frame_length)
                  report_mismatch("frame_length", 32'(want.frame_length),
                                  32'(got.frame_length));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Idling, back-pressure and watchdog
   // ------------------------------------------------------------------

   // The run passes through three idling regimes keyed on accepted bytes:
   // a slow receiver first, then a slow sender, then neither idles.
   function automatic int idle_stage();
      if (in_accepted < ITEMS / 3) return 0;
      if (in_accepted < 2 * ITEMS / 3) return 1;
      return 2;
   endfunction

   function automatic int sender_gap_pct();
      case (idle_stage())
         0: return 25;
         1: return 85;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_stage())
         0: return 85;
         1: return 25;
         default: return 0;
      endcase
   endfunction

   // Receiver side. Once, in the stage without idling, it holds off for a long
   // stretch while the sender keeps offering, so the internal queue fills up
   // and the block has to stall its input.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && in_accepted >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct());
      end
   end

   // The watchdog counts cycles without any transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Puts up one byte and returns at the clock edge where it is taken. A
   // random number of idle cycles may come first. Between back-to-back
   // transfers valid stays high, so it is never lowered and raised at once.
   task automatic send_item(input req_type item, input logic fixed, input rsp_type rsp);
      int          gap_pct;
      dir_row_type typed;
      gap_pct = sender_gap_pct();
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      typed.item = item;
      typed.fixed = fixed;
      typed.rsp = rsp;
      hand_typed.push_back(typed);
      req_valid <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      offered++;
   endtask

   task automatic send_byte(input logic [7:0] data);
      req_type item;
      item.data_byte = data;
      item.end_of_stream = 1'b0;
      send_item(item, 1'b0, '0);
   endtask

   // The data byte rides along with end of stream at random; it is ignored.
   task automatic send_eos();
      req_type item;
      item.data_byte = 8'($urandom_range(255));
      item.end_of_stream = 1'b1;
      send_item(item, 1'b0, '0);
   endtask

   task automatic send_header(input logic [31:0] len);
      for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
   endtask

   task automatic send_payload();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
   endtask

   // Writes max_payload while the block is idle: no byte in flight and every
   // owed result delivered, plus a few cycles of margin. The first edge lets
   // the scoreboard log the byte taken at the edge the caller returned on.
   task automatic write_max(input int value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value[LEN_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_max = value;
   endtask

   function automatic logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(63));
   endfunction

   // Appends one well-formed character of at most room bytes. The lead ranges
   // follow the strict rules, so the second byte is narrowed after E0, ED, F0
   // and F4 to stay clear of overlong forms, surrogates and values past 10FFFF.
   function automatic void add_char(input int room);
      int         pick;
      logic [7:0] lead;
      pick = $urandom_range(9);
      if (room >= 4 && pick == 9) begin
         case ($urandom_range(2))
            0: begin
               frame_bytes.push_back(8'hf0);
               frame_bytes.push_back(8'h90 + 8'($urandom_range(47)));
            end
            1: begin
               frame_bytes.push_back(8'($urandom_range(8'hf1, 8'hf3)));
               frame_bytes.push_back(cont_byte());
            end
            default: begin
               frame_bytes.push_back(8'hf4);
               frame_bytes.push_back(8'h80 + 8'($urandom_range(15)));
            end
         endcase
         frame_bytes.push_back(cont_byte());
         frame_bytes.push_back(cont_byte());
      end else if (room >= 3 && pick >= 7) begin
         case ($urandom_range(2))
            0: begin
               frame_bytes.push_back(8'he0);
               frame_bytes.push_back(8'ha0 + 8'($urandom_range(31)));
            end
            1: begin
               frame_bytes.push_back(8'hed);
               frame_bytes.push_back(8'h80 + 8'($urandom_range(31)));
            end
            default: begin
               do lead = 8'($urandom_range(8'he1, 8'hef)); while (lead == 8'hed);
               frame_bytes.push_back(lead);
               frame_bytes.push_back(cont_byte());
            end
         endcase
         frame_bytes.push_back(cont_byte());
      end else if (room >= 2 && pick >= 5) begin
         frame_bytes.push_back(8'($urandom_range(8'hc2, 8'hdf)));
         frame_bytes.push_back(cont_byte());
      end else if ($urandom_range(19) == 0) begin
         frame_bytes.push_back(8'h09);
      end else begin
         frame_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
      end
   endfunction

   function automatic void build_frame(input int len);
      frame_bytes.delete();
      while (frame_bytes.size() < len) add_char(len - frame_bytes.size());
   endfunction

   // Mostly short frames; now and then, with max_payload at most 200, one of
   // exactly max_payload bytes, or a longer one up to 200 bytes when the register allows it.
   function automatic int pick_len();
      int cap;
      cap = (cur_max > 200) ? 200 : cur_max;
      if ($urandom_range(5) == 0 && cur_max <= 200) return cur_max;
      if ($urandom_range(24) != 0 && cap > 24) cap = 24;
      return $urandom_range(1, cap);
   endfunction

   // Well-formed frames with random content, with clean ends of stream at
   // frame boundaries sprinkled in.
   task automatic random_frames(input int until_offered);
      int len;
      while (offered < until_offered) begin
         if ($urandom_range(15) == 0) begin
            send_eos();
         end else begin
            len = pick_len();
            build_frame(len);
            send_header(len);
            send_payload();
         end
      end
   endtask

   // Appends one sequence that breaks strict UTF-8 in a way other than
   // running into the end of the frame.
   function automatic void add_bad_sequence();
      case ($urandom_range(7))
         0: frame_bytes.push_back(cont_byte());                        // stray continuation
         1: begin                                                      // always-overlong lead
            frame_bytes.push_back(8'hc0 | 8'($urandom_range(1)));
            frame_bytes.push_back(cont_byte());
         end
         2: frame_bytes.push_back(8'($urandom_range(8'hf5, 8'hff)));   // lead past F4
         3: begin                                                      // overlong 3-byte
            frame_bytes.push_back(8'he0);
            frame_bytes.push_back(8'h80 + 8'($urandom_range(31)));
            frame_bytes.push_back(cont_byte());
         end
         4: begin                                                      // overlong 4-byte
            frame_bytes.push_back(8'hf0);
            frame_bytes.push_back(8'h80 + 8'($urandom_range(15)));
            frame_bytes.push_back(cont_byte());
            frame_bytes.push_back(cont_byte());
         end
         5: begin                                                      // surrogate
            frame_bytes.push_back(8'hed);
            frame_bytes.push_back(8'ha0 + 8'($urandom_range(31)));
            frame_bytes.push_back(cont_byte());
         end
         6: begin                                                      // above 10FFFF
            frame_bytes.push_back(8'hf4);
            frame_bytes.push_back(8'h90 + 8'($urandom_range(47)));
            frame_bytes.push_back(cont_byte());
            frame_bytes.push_back(cont_byte());
         end
         default: begin                                                // missing continuation
            frame_bytes.push_back(8'($urandom_range(8'hc2, 8'hdf)));
            if ($urandom_range(1) == 0) frame_bytes.push_back(8'($urandom_range(8'h7f)));
            else frame_bytes.push_back(8'($urandom_range(8'hc0, 8'hff)));
         end
      endcase
   endfunction

   // Ends the stream in one randomly chosen protocol error, then keeps sending
   // noise to show that every later result stays a protocol error.
   task automatic break_stream();
      break_kind_type kind;
      int             len;
      int             cut;
      int             need;
      logic [7:0]     bad;
      kind = break_kind_type'($urandom_range(7));
      if (kind == BRK_NO_MAX) write_max(0);
      else write_max($urandom_range(20, MAX_REG));
      case (kind)
         BRK_ZERO_LEN: send_header(32'd0);
         BRK_OVER_LEN: begin
            if ($urandom_range(1) == 0) send_header(cur_max + 1);
            else send_header({8'($urandom_range(1, 255)), 24'($urandom)});
         end
         BRK_NO_MAX: send_header($urandom_range(1, 16));
         BRK_EOS_HEADER: begin
            cut = $urandom_range(1, 3);
            repeat (cut) send_byte(8'($urandom_range(255)));
            send_eos();
         end
         BRK_EOS_PAYLOAD: begin
            len = $urandom_range(2, 12);
            build_frame(len);
            send_header(len);
            cut = $urandom_range(len - 1);
            for (int i = 0; i < cut; i++) send_byte(frame_bytes[i]);
            send_eos();
         end
         BRK_BAD_CLASS: begin
            len = $urandom_range(1, 12);
            build_frame(len);
            case ($urandom_range(4))
               0: bad = 8'h00;
               1: bad = 8'h0a;
               2: bad = 8'h0d;
               3: bad = 8'h7f;
               default: do bad = 8'($urandom_range(8'h01, 8'h1f)); while (bad == 8'h09);
            endcase
            frame_bytes[$urandom_range(len - 1)] = bad;
            send_header(len);
            send_payload();
         end
         BRK_BAD_UTF8: begin
            build_frame($urandom_range(6));
            add_bad_sequence();
            repeat ($urandom_range(4)) frame_bytes.push_back(8'($urandom_range(255)));
            send_header(frame_bytes.size());
            send_payload();
         end
         default: begin
            // A sequence cut off by the end of the frame. The leads are picked
            // so that any continuation byte is legal after them.
            build_frame($urandom_range(6));
            case ($urandom_range(2))
               0: begin
                  frame_bytes.push_back(8'($urandom_range(8'hc2, 8'hdf)));
                  need = 1;
               end
               1: begin
                  frame_bytes.push_back(8'($urandom_range(8'he1, 8'hec)));
                  need = 2;
               end
               default: begin
                  frame_bytes.push_back(8'($urandom_range(8'hf1, 8'hf3)));
                  need = 3;
               end
            endcase
            repeat ($urandom_range(need - 1)) frame_bytes.push_back(cont_byte());
            send_header(frame_bytes.size());
            send_payload();
         end
      endcase
      repeat ($urandom_range(5, 15)) begin
         if ($urandom_range(3) == 0) send_eos();
         else send_byte(8'($urandom_range(255)));
      end
   endtask

   // Directed rows. A row with a typed result carries the status code and the
   // fields the result must show; a row without one is left to the scoreboard.
   function automatic dir_row_type typed_row(input logic [7:0] data, input logic eos,
                                             input logic [1:0] status,
                                             input logic [7:0] pbyte,
                                             input logic pvalid, input logic last,
                                             input logic [20:0] flen);
      dir_row_type r;
      r.item.data_byte = data;
      r.item.end_of_stream = eos;
      r.fixed = 1'b1;
      r.rsp.status = status;
      r.rsp.payload_byte = pbyte;
      r.rsp.payload_byte_valid = pvalid;
      r.rsp.frame_last = last;
      r.rsp.frame_length = flen;
      return r;
   endfunction

   function automatic dir_row_type checked_row(input logic [7:0] data);
      dir_row_type r;
      r = '0;
      r.item.data_byte = data;
      return r;
   endfunction

   initial begin
      // Clean end straight out of reset and again; a one-byte frame; then a
      // 14-byte frame with tab, the top printable byte and the boundary
      // characters U+0080, U+0800, U+D7FF and U+10FFFF; then a clean end.
      directed_rows = '{
         typed_row(8'ha5, 1'b1, ST_CLEAN_END, 8'h00, 1'b0, 1'b0, 21'd0),
         typed_row(8'h00, 1'b1, ST_CLEAN_END, 8'h00, 1'b0, 1'b0, 21'd0),
         typed_row(8'h00, 1'b0, ST_BUSY, 8'h00, 1'b0, 1'b0, 21'd0),
         typed_row(8'h00, 1'b0, ST_BUSY, 8'h00, 1'b0, 1'b0, 21'd0),
         typed_row(8'h00, 1'b0, ST_BUSY, 8'h00, 1'b0, 1'b0, 21'd0),
         typed_row(8'h01, 1'b0, ST_BUSY, 8'h00, 1'b0, 1'b0, 21'd1),
         typed_row(8'h41, 1'b0, ST_FRAME_OK, 8'h41, 1'b1, 1'b1, 21'd1),
         typed_row(8'h00, 1'b0, ST_BUSY, 8'h00, 1'b0, 1'b0, 21'd0),
         typed_row(8'h00, 1'b0, ST_BUSY, 8'h00, 1'b0, 1'b0, 21'd0),
         typed_row(8'h00, 1'b0, ST_BUSY, 8'h00, 1'b0, 1'b0, 21'd0),
         typed_row(8'h0e, 1'b0, ST_BUSY, 8'h00, 1'b0, 1'b0, 21'd14),
         checked_row(8'h09),
         checked_row(8'h7e),
         checked_row(8'hc2), checked_row(8'h80),
         checked_row(8'he0), checked_row(8'ha0), checked_row(8'h80),
         checked_row(8'hed), checked_row(8'h9f), checked_row(8'hbf),
         checked_row(8'hf4), checked_row(8'h8f), checked_row(8'hbf), checked_row(8'hbf),
         typed_row(8'h00, 1'b1, ST_CLEAN_END, 8'h00, 1'b0, 1'b0, 21'd0)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with max_payload at its reset value.
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].rsp);

      // Smallest legal register value: only one-byte frames pass.
      write_max(1);
      random_frames(90);

      // A large register value, MAX_REG, with some longer frames.
      write_max(MAX_REG);
      random_frames(330);

      // Small random limits, so frames of exactly max_payload bytes are common.
      write_max($urandom_range(2, 48));
      random_frames(ITEMS);

      break_stream();

      // Drain: every owed result must arrive, then a short quiet spell shows
      // that nothing extra comes out. The first edge lets the scoreboard log
      // the last byte taken. The watchdog bounds both waits.
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
